// ===== rtl/btb_pkg.sv =====
// ----------------------------------------------------------------------------
// btb_pkg
// Shared types, constants and helpers of the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btb_pkg;

    localparam int ROW_CNT_BITS = 8;
    localparam int TAG_W        = 30;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_BITS  = 3'd0,
        CFG_TAG_BITS    = 3'd1,
        CFG_HIST_LEN    = 3'd2,
        CFG_CNT_INIT    = 3'd3,
        CFG_GLOBAL_HIST = 3'd4,
        CFG_GLOBAL_TBL  = 3'd5,
        CFG_SHARE_MODE  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LSB  = 2'd1,
        SHARE_MID  = 2'd2,
        SHARE_ALT  = 2'd3
    } t_share;

    localparam int SHARE_LSB_POS = 2;
    localparam int SHARE_MID_POS = 16;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_WALK = 5'b00100,
        S_WR   = 5'b01000,
        S_CLR  = 5'b10000
    } t_state;

    function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
        logic [1:0] r;
        r = c;
        if (up) begin
            if (c != 2'd3) r = c + 2'd1;
        end else begin
            if (c != 2'd0) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/btb_ctr_mem.sv =====
// ----------------------------------------------------------------------------
// btb_ctr_mem
// Single-port counter RAM with registered read.
// ----------------------------------------------------------------------------
module btb_ctr_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [1:0]    i_wdata,
    output logic [1:0]    o_rdata
);
    logic [1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule

// ===== rtl/btb_two_level_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with two-level direction prediction; counters in RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  request  | i_start, o_busy         | i_action i_pc i_target_pc i_taken
//           |                         | i_predicted_dst
//  result   | o_done (one cycle)      | o_predict_taken o_next_pc o_flushed
//           |                         | o_branch_count o_flush_count
//  config   | i_cfg_we                | i_cfg_idx i_cfg_data
//
// Without a row walk, the counter RAM is read at the transfer and an update writes back next.
// An update that changes a row tag with local counters walks the row first,
// the single RAM port writing one counter per cycle.
// After reset, and after a counter_init write while idle or clearing, the RAM
// is cleared with o_busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor
    import btb_pkg::*;
#(
    parameter int ENTRIES     = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_action,
    input  logic [31:0]           i_pc,
    input  logic [31:0]           i_target_pc,
    input  logic                  i_taken,
    input  logic [31:0]           i_predicted_dst,
    output logic                  o_done,
    output logic                  o_predict_taken,
    output logic [31:0]           o_next_pc,
    output logic                  o_flushed,
    output logic [31:0]           o_branch_count,
    output logic [31:0]           o_flush_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int RW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW    = RW + ROW_CNT_BITS;
    localparam int DEPTH = ENTRIES * (2 ** ROW_CNT_BITS);
    localparam int MH    = MAX_HISTORY;

    logic [2:0] r_ib;
    logic [4:0] r_tb;
    logic [3:0] r_hl;
    logic [1:0] r_ci;
    logic       r_gh;
    logic       r_gt;
    logic [1:0] r_sm;

    logic [TAG_W-1:0] r_tag  [ENTRIES];
    logic [31:0]      r_tgt  [ENTRIES];
    logic [MH-1:0]    r_hist [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [31:0]      r_branches;
    logic [31:0]      r_flushes;

    t_state           r_state;
    logic [AW-1:0]    r_cnt;
    logic [AW-1:0]    r_addr;
    logic [RW-1:0]    r_row;
    logic             r_act;
    logic             r_taken;
    logic             r_hit;
    logic             r_flush;
    logic [31:0]      r_pc;
    logic [31:0]      r_hit_tgt;

    logic [RW-1:0]    row_lut [128];
    logic             accept;
    logic [29:0]      pcw;
    logic [6:0]       raw_row;
    logic [RW-1:0]    row;
    logic [RW-1:0]    hrow;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] tag_mask;
    logic [3:0]       hl_eff;
    logic [MH:0]      hm_w;
    logic [MH-1:0]    hmask;
    logic [MH-1:0]    hist_eff;
    logic [MH-1:0]    share;
    logic [MH-1:0]    cidx;
    logic [MH-1:0]    hist_new;
    logic             tag_chg;
    logic             flush_now;
    logic [AW-1:0]    acc_addr;
    logic [31:0]      fall_pc;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [1:0]       mem_wdata;
    logic [1:0]       mem_rdata;

    for (genvar g = 0; g < 128; g++) begin : g_row_lut
        assign row_lut[g] = RW'(g % ENTRIES);
    end

    assign accept  = i_start && !o_busy;
    assign o_busy  = (r_state != S_IDLE);
    assign pcw     = i_pc[31:2];
    assign raw_row = pcw[6:0] & 7'((8'd1 << r_ib) - 8'd1);
    assign row     = row_lut[raw_row];
    assign hrow    = r_gh ? '0 : row;
    assign tag_mask = (r_tb >= 5'd30) ? '1 : ((TAG_W'(1) << r_tb) - TAG_W'(1));
    assign tag     = pcw & tag_mask;
    assign tag_chg = (r_tag[row] != tag);
    assign fall_pc = i_pc + 32'd4;

    always_comb begin
        hl_eff = r_hl;
        if (r_hl == 4'd0) hl_eff = 4'd1;
        if (r_hl > 4'(MH)) hl_eff = 4'(MH);
    end

    assign hm_w     = ((MH+1)'(1) << hl_eff) - (MH+1)'(1);
    assign hmask    = hm_w[MH-1:0];
    assign hist_eff = (i_action && tag_chg && !r_gh) ? '0 : r_hist[hrow];

    always_comb begin
        case (r_sm)
            SHARE_NONE: share = '0;
            SHARE_LSB:  share = i_pc[SHARE_LSB_POS +: MH];
            default:    share = i_pc[SHARE_MID_POS +: MH];
        endcase
    end

    assign cidx      = (share ^ hist_eff) & hmask;
    assign acc_addr  = {(r_gt ? RW'(0) : row), ROW_CNT_BITS'(cidx)};
    assign hist_new  = ((hist_eff & (hmask >> 1)) << 1) | MH'(i_taken);
    assign flush_now = i_taken ? (i_predicted_dst != i_target_pc)
                               : (i_predicted_dst != fall_pc);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = acc_addr;
        mem_wdata = r_ci;
        case (r_state)
            S_IDLE: begin
                mem_addr = acc_addr;
            end
            S_EVAL: begin
                mem_we    = r_act;
                mem_addr  = r_addr;
                mem_wdata = sat_step(mem_rdata, r_taken);
            end
            S_WALK: begin
                mem_we   = 1'b1;
                mem_addr = {r_row, r_cnt[ROW_CNT_BITS-1:0]};
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_addr;
                mem_wdata = sat_step(r_ci, r_taken);
            end
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_cnt;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    btb_ctr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctr_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib       <= '0;
            r_tb       <= '0;
            r_hl       <= 4'd1;
            r_ci       <= 2'd1;
            r_gh       <= 1'b0;
            r_gt       <= 1'b0;
            r_sm       <= '0;
            r_valid    <= '0;
            r_branches <= '0;
            r_flushes  <= '0;
            r_state    <= S_CLR;
            r_cnt      <= '0;
            o_done     <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_tag[i]  <= '0;
                r_hist[i] <= '0;
            end
        end else begin
            o_done <= (r_state == S_EVAL) || (r_state == S_WR);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INDEX_BITS:  r_ib <= i_cfg_data[2:0];
                    CFG_TAG_BITS:    r_tb <= i_cfg_data;
                    CFG_HIST_LEN:    r_hl <= i_cfg_data[3:0];
                    CFG_CNT_INIT:    r_ci <= i_cfg_data[1:0];
                    CFG_GLOBAL_HIST: r_gh <= i_cfg_data[0];
                    CFG_GLOBAL_TBL:  r_gt <= i_cfg_data[0];
                    CFG_SHARE_MODE:  r_sm <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we && i_cfg_idx == CFG_CNT_INIT) begin
                        r_state <= S_CLR;
                        r_cnt   <= '0;
                    end else if (accept) begin
                        r_act     <= i_action;
                        r_taken   <= i_taken;
                        r_pc      <= i_pc;
                        r_row     <= row;
                        r_addr    <= acc_addr;
                        r_hit     <= r_valid[row] && !tag_chg;
                        r_hit_tgt <= r_tgt[row];
                        r_flush   <= flush_now;
                        r_cnt     <= '0;
                        r_state   <= (i_action && tag_chg && !r_gt) ? S_WALK : S_EVAL;
                        if (i_action) begin
                            r_branches   <= r_branches + 32'd1;
                            if (flush_now) r_flushes <= r_flushes + 32'd1;
                            r_tag[row]   <= tag;
                            r_tgt[row]   <= i_target_pc;
                            r_valid[row] <= 1'b1;
                            r_hist[hrow] <= hist_new;
                        end
                    end
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (&r_cnt[ROW_CNT_BITS-1:0]) r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    if (i_cfg_we && i_cfg_idx == CFG_CNT_INIT) begin
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                        if (r_cnt == AW'(DEPTH - 1)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL || r_state == S_WR) begin
            o_predict_taken <= !r_act && r_hit && mem_rdata[1];
            o_next_pc       <= r_act ? 32'd0 :
                               ((r_hit && mem_rdata[1]) ? r_hit_tgt : r_pc + 32'd4);
            o_flushed       <= r_act && r_flush;
            o_branch_count  <= r_branches;
            o_flush_count   <= r_flushes;
        end
    end

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL || r_state == S_WALK))
        else $error("transfer did not start an item");

    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$past(o_done))
        else $error("results back to back");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_EVAL || $past(r_state) == S_WR))
        else $error("result without write-back");

    a_walk_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (!r_gt && r_act))
        else $error("row walk on shared table");
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level BTB predictor: a behavioral copy of
// the BTB state predicts every result, random traffic (with idle bursts in all
// but the last setting) walks several register settings including the extremes.
// ----------------------------------------------------------------------------
module testbench;
    import btb_pkg::*;

    localparam int  ROWS      = 32;
    localparam int  MAX_HIST  = 8;
    localparam int  LIMIT     = 3000000;

    typedef struct packed {
        logic        ptaken;
        logic [31:0] npc;
        logic        flushed;
        logic [31:0] bcnt;
        logic [31:0] fcnt;
    } t_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        i_action = 0;
    logic [31:0] i_pc = 0;
    logic [31:0] i_target_pc = 0;
    logic        i_taken = 0;
    logic [31:0] i_predicted_dst = 0;
    logic        i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;
    logic        o_busy, o_done, o_predict_taken, o_flushed;
    logic [31:0] o_next_pc, o_branch_count, o_flush_count;

    btb_two_level_branch_predictor DUT (.*);

    initial forever #5 i_clk = ~i_clk;

    // predictor state
    logic [2:0]  m_index_bits;
    logic [4:0]  m_tag_bits;
    logic [3:0]  m_hist_len;
    logic [1:0]  m_cnt_init;
    logic        m_ghist, m_gtbl;
    logic [1:0]  m_share;
    logic [29:0] m_tag [ROWS];
    logic [31:0] m_target [ROWS];
    logic        m_valid [ROWS];
    logic [7:0]  m_hist [ROWS];
    logic [1:0]  m_cnt [8192];
    logic [31:0] m_branches, m_flushes;

    t_result     pending_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          n_pred = 0, n_upd = 0, n_results = 0;
    bit          allow_idle = 1;
    logic [31:0] pc_pool [8];

    function automatic int eff_hist();
        if (m_hist_len < 1) return 1;
        if (m_hist_len > MAX_HIST) return MAX_HIST;
        return m_hist_len;
    endfunction

    function automatic int row_of(logic [31:0] pc);
        logic [31:0] mask;
        mask = (32'd1 << m_index_bits) - 1;
        return ((pc >> 2) & mask) % ROWS;
    endfunction

    function automatic logic [29:0] tag_of(logic [31:0] pc);
        logic [63:0] mask;
        mask = (64'd1 << m_tag_bits) - 1;
        return 30'(64'(pc >> 2) & mask);
    endfunction

    function automatic int cnt_addr(int row, logic [31:0] pc, logic [7:0] hist);
        logic [31:0] hmask, sh;
        int base;
        hmask = (32'd1 << eff_hist()) - 1;
        sh = 0;
        base = m_gtbl ? 0 : row;
        if (m_share == SHARE_LSB) sh = (pc >> SHARE_LSB_POS) & hmask;
        else if (m_share >= SHARE_MID) sh = (pc >> SHARE_MID_POS) & hmask;
        return (base * 256 + ((sh ^ 32'(hist)) & hmask)) & 8191;
    endfunction

    function automatic logic [31:0] predict_next(logic [31:0] pc);
        int row, hrow;
        row = row_of(pc);
        hrow = m_ghist ? 0 : row;
        if (m_valid[row] && m_tag[row] == tag_of(pc) &&
            m_cnt[cnt_addr(row, pc, m_hist[hrow])] >= 2)
            return m_target[row];
        return pc + 32'd4;
    endfunction

    task automatic model_reset();
        m_index_bits = 0; m_tag_bits = 0; m_hist_len = 1; m_cnt_init = 1;
        m_ghist = 0; m_gtbl = 0; m_share = SHARE_NONE;
        for (int i = 0; i < ROWS; i++) begin
            m_tag[i] = 0; m_target[i] = 0; m_valid[i] = 0; m_hist[i] = 0;
        end
        foreach (m_cnt[i]) m_cnt[i] = 1;
        m_branches = 0; m_flushes = 0;
    endtask

    task automatic model_item(logic act, logic [31:0] pc, logic [31:0] tgt,
                              logic tk, logic [31:0] pdst);
        t_result r;
        int row, hrow, a;
        logic [7:0] h;
        logic [31:0] hmask;
        row = row_of(pc);
        hrow = m_ghist ? 0 : row;
        r = '0;
        if (!act) begin
            r.npc = predict_next(pc);
            r.ptaken = (r.npc != pc + 32'd4) || (m_valid[row] && m_tag[row] == tag_of(pc)
                       && m_cnt[cnt_addr(row, pc, m_hist[hrow])] >= 2);
            n_pred++;
        end else begin
            m_branches++;
            r.flushed = tk ? (pdst != tgt) : (pdst != pc + 32'd4);
            if (r.flushed) m_flushes++;
            if (m_tag[row] != tag_of(pc)) begin
                if (!m_ghist) m_hist[row] = 0;
                if (!m_gtbl) for (int i = 0; i < 256; i++) m_cnt[row * 256 + i] = m_cnt_init;
            end
            m_tag[row] = tag_of(pc);
            m_target[row] = tgt;
            h = m_hist[hrow];
            hmask = (32'd1 << eff_hist()) - 1;
            m_hist[hrow] = 8'((((32'(h) & (hmask >> 1)) << 1) + tk));
            a = cnt_addr(row, pc, h);
            m_cnt[a] = sat_step(m_cnt[a], tk);
            m_valid[row] = 1;
            n_upd++;
        end
        r.bcnt = m_branches;
        r.fcnt = m_flushes;
        pending_results.push_back(r);
    endtask

    // caller is at a rising edge; returns at the transfer edge with start still high
    task automatic send_item(logic act, logic [31:0] pc, logic [31:0] tgt,
                             logic tk, logic [31:0] pdst);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            i_start <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_start <= 1;
        i_action <= act; i_pc <= pc; i_target_pc <= tgt;
        i_taken <= tk; i_predicted_dst <= pdst;
        do @(posedge i_clk); while (o_busy);
        model_item(act, pc, tgt, tk, pdst);
    endtask

    task automatic drain();
        i_start <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [4:0] data);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_INDEX_BITS:  m_index_bits = data[2:0];
            CFG_TAG_BITS:    m_tag_bits = data;
            CFG_HIST_LEN:    m_hist_len = data[3:0];
            CFG_CNT_INIT: begin
                m_cnt_init = data[1:0];
                foreach (m_cnt[i]) m_cnt[i] = data[1:0];
            end
            CFG_GLOBAL_HIST: m_ghist = data[0];
            CFG_GLOBAL_TBL:  m_gtbl = data[0];
            CFG_SHARE_MODE:  m_share = t_share'(data[1:0]);
            default: ;
        endcase
        i_cfg_we <= 0;
        repeat (3) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic configure(int ib, int tb, int hl, int ci, int gh, int gt, int sm);
        drain();
        cfg_write(CFG_INDEX_BITS, 5'(ib));
        cfg_write(CFG_TAG_BITS, 5'(tb));
        cfg_write(CFG_HIST_LEN, 5'(hl));
        cfg_write(CFG_CNT_INIT, 5'(ci));
        cfg_write(CFG_GLOBAL_HIST, 5'(gh));
        cfg_write(CFG_GLOBAL_TBL, 5'(gt));
        cfg_write(CFG_SHARE_MODE, 5'(sm));
    endtask

    task automatic test_directed();
        logic [31:0] p;
        send_item(0, 32'h0, 32'h0, 0, 32'h0);
        send_item(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        send_item(1, 32'hFFFF_FFFC, 32'h1234_5678, 1, 32'h1234_5678);
        send_item(1, 32'hFFFF_FFFC, 32'h1234_5678, 1, 32'h0);
        send_item(0, 32'hFFFF_FFFC, 32'h0, 0, 32'h0);
        send_item(1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 0, 32'h0);
        send_item(1, 32'h0000_0100, 32'h0000_0200, 1, 32'h0000_0104);
        send_item(1, 32'h0000_0100, 32'h0000_0200, 1, 32'h0000_0200);
        send_item(0, 32'h0000_0100, 32'h0, 0, 32'h0);
        send_item(1, 32'h8000_0100, 32'hAAAA_5555, 0, 32'h8000_0104);
        send_item(0, 32'h8000_0100, 32'h0, 1, 32'hFFFF_FFFF);
        configure(5, 30, 8, 3, 0, 0, SHARE_LSB);
        for (int i = 0; i < 6; i++) begin
            p = 32'h0001_0040 + 32'(i) * 32'h0001_0004;
            send_item(1, p, ~p, 1'(i % 2), predict_next(p));
            send_item(0, p, 32'h0, 0, 32'h0);
        end
    endtask

    // well-formed branch streams over a small address pool, with some noise
    task automatic test_random(int n);
        logic [31:0] p, t, d;
        logic tk;
        foreach (pc_pool[i]) pc_pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                p = pc_pool[$urandom_range(0, 7)];
                t = ($urandom_range(0, 3) == 0) ? $urandom : p ^ 32'h0000_0F00;
                tk = $urandom_range(0, 2) != 0;
                send_item(0, p, $urandom, 1'($urandom_range(0, 1)), $urandom);
                d = predict_next(p);
                if ($urandom_range(0, 4) == 0) d = $urandom;
                send_item(1, p, t, tk, d);
                i++;
            end else begin
                send_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                          1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_predict_taken !== e.ptaken) report("predict_taken", o_predict_taken, e.ptaken);
                if (o_next_pc !== e.npc) report("next_pc", o_next_pc, e.npc);
                if (o_flushed !== e.flushed) report("flushed", o_flushed, e.flushed);
                if (o_branch_count !== e.bcnt) report("branch_count", o_branch_count, e.bcnt);
                if (o_flush_count !== e.fcnt) report("flush_count", o_flush_count, e.fcnt);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        test_directed();
        configure(7, 31, 0, 0, 1, 1, SHARE_MID);
        test_random(270);
        configure(3, 4, 15, 2, 1, 0, SHARE_ALT);
        test_random(270);
        configure(0, 0, 1, 0, 0, 1, SHARE_NONE);
        test_random(270);
        configure(5, 30, 8, 3, 0, 0, SHARE_LSB);
        test_random(270);
        configure(2, 12, 4, 1, 0, 0, SHARE_MID);
        test_random(270);
        configure(4, 3, 2, 2, 1, 1, SHARE_LSB);
        allow_idle = 0;
        test_random(270);
        drain();
        $display("covered %0d predicts and %0d updates, %0d results, over seven settings",
                 n_pred, n_upd, n_results);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
